@@ hw/rtl/u8dec_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8dec_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [7:0] AsciiLimit = 8'h80;
	localparam logic [7:0] ContMask   = 8'hC0;
	localparam logic [7:0] ContCode   = 8'h80;
	localparam logic [7:0] Lead2Mask  = 8'hE0;
	localparam logic [7:0] Lead2Code  = 8'hC0;
	localparam logic [7:0] Lead3Mask  = 8'hF0;
	localparam logic [7:0] Lead3Code  = 8'hE0;
	localparam logic [7:0] Lead4Mask  = 8'hF8;
	localparam logic [7:0] Lead4Code  = 8'hF0;
	localparam logic [7:0] Pay2Mask   = 8'h1F;
	localparam logic [7:0] Pay3Mask   = 8'h0F;
	localparam logic [7:0] Pay4Mask   = 8'h07;
	localparam logic [7:0] ContPayMask = 8'h3F;

	localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

	localparam logic [2:0] SeqNone = 3'd0;
	localparam logic [2:0] SeqLen2 = 3'd2;
	localparam logic [2:0] SeqLen3 = 3'd3;
	localparam logic [2:0] SeqLen4 = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               run_last;
		logic               text_done;
	} out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/utf8_stream_decoder_core.sv @@
// Top level of the UTF-8 stream decoder: byte decode and result run register.
//
//  channel | direction | payload    | transfer
//  src     | in        | in_item_t  | src_valid & src_ready
//  dst     | out       | out_item_t | dst_valid & dst_ready
//
// While src_ready is high, one byte is decoded per cycle into a run of zero to four results held in the run register.
// A run presents its results on dst one at a time; src_ready stays low until its last result can transfer.
// src_ready is high when the run register is empty or its last result transfers this cycle.
// Reset clears the open sequence and empties the run register.
// A stall on dst holds the run register and, once its last result waits, src as well.
`default_nettype none

module utf8_stream_decoder_core import u8dec_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output      logic      src_ready,
	input  wire in_item_t  src_data,
	output      logic      dst_valid,
	input  wire logic      dst_ready,
	output      out_item_t dst_data
);

	logic [CpWidth-1:0] acc_q;
	logic [2:0]         exp_q;
	logic [1:0]         held_q;

	logic               run_valid_q;
	logic [1:0]         run_rep_q;
	logic               run_tail_q;
	logic [CpWidth-1:0] run_cp_q;
	logic               run_end_q;

	logic               src_xfer;
	logic               dst_xfer;
	logic               run_is_last;

	logic [CpWidth-1:0] acc_d;
	logic [2:0]         exp_d;
	logic [1:0]         held_d;
	logic [1:0]         rep_d;
	logic               tail_d;
	logic [CpWidth-1:0] cp_d;

	assign run_is_last = (run_rep_q == 2'd0) || (run_rep_q == 2'd1 && !run_tail_q);
	assign dst_valid   = run_valid_q;
	assign dst_xfer    = dst_valid && dst_ready;
	assign src_ready   = !run_valid_q || (dst_ready && run_is_last);
	assign src_xfer    = src_valid && src_ready;

	always_comb begin
		dst_data.code_point = (run_rep_q != 2'd0) ? Replacement : run_cp_q;
		dst_data.run_last   = run_is_last;
		dst_data.text_done  = run_is_last && run_end_q;
	end

	always_comb begin
		logic [7:0]         b;
		logic               fin;
		logic               open;
		logic [CpWidth-1:0] acc_cont;
		logic [2:0]         count;
		logic [2:0]         len;
		logic [CpWidth-1:0] payload;
		b        = src_data.in_byte;
		fin      = src_data.text_end;
		open     = (exp_q != SeqNone);
		acc_cont = {acc_q[CpWidth-7:0], (b & ContPayMask) >> 0 == 8'd0 ? 6'd0 : b[5:0]};
		count    = {1'b0, held_q} + 3'd1;
		len      = SeqNone;
		payload  = '0;
		acc_d    = '0;
		exp_d    = SeqNone;
		held_d   = 2'd0;
		rep_d    = 2'd0;
		tail_d   = 1'b0;
		cp_d     = Replacement;
		if (open && (b & ContMask) == ContCode) begin
			if (count >= exp_q) begin
				tail_d = 1'b1;
				cp_d   = acc_cont;
			end else if (fin) begin
				rep_d = count[1:0];
			end else begin
				acc_d  = acc_cont;
				exp_d  = exp_q;
				held_d = count[1:0];
			end
		end else begin
			rep_d = open ? held_q : 2'd0;
			if (b < AsciiLimit) begin
				tail_d = 1'b1;
				cp_d   = {{(CpWidth-8){1'b0}}, b};
			end else begin
				priority if ((b & Lead2Mask) == Lead2Code) begin
					len     = SeqLen2;
					payload = {{(CpWidth-8){1'b0}}, b & Pay2Mask};
				end else if ((b & Lead3Mask) == Lead3Code) begin
					len     = SeqLen3;
					payload = {{(CpWidth-8){1'b0}}, b & Pay3Mask};
				end else if ((b & Lead4Mask) == Lead4Code) begin
					len     = SeqLen4;
					payload = {{(CpWidth-8){1'b0}}, b & Pay4Mask};
				end else begin
					len = SeqNone;
				end
				if (len == SeqNone || fin) begin
					tail_d = 1'b1;
				end else begin
					acc_d  = payload;
					exp_d  = len;
					held_d = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			exp_q  <= SeqNone;
			held_q <= 2'd0;
		end else if (src_xfer) begin
			acc_q  <= acc_d;
			exp_q  <= exp_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_rep_q   <= 2'd0;
			run_tail_q  <= 1'b0;
		end else if (src_xfer) begin
			run_valid_q <= tail_d || (rep_d != 2'd0);
			run_rep_q   <= rep_d;
			run_tail_q  <= tail_d;
		end else if (dst_xfer) begin
			if (run_is_last) begin
				run_valid_q <= 1'b0;
				run_rep_q   <= 2'd0;
				run_tail_q  <= 1'b0;
			end else begin
				run_rep_q <= run_rep_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			run_cp_q  <= cp_d;
			run_end_q <= src_data.text_end;
		end
	end

`ifndef SYNTHESIS
	a_held_tracks_open: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q == SeqNone) == (held_q == 2'd0))
		else $error("held count disagrees with open sequence");

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != SeqNone) |-> ({1'b0, held_q} < exp_q))
		else $error("held count reached sequence length");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(src_xfer && src_data.text_end) |=> (exp_q == SeqNone && run_valid_q))
		else $error("text end left a sequence open or gave no result");

	a_ready_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(run_valid_q && src_ready) |-> (dst_data.run_last && dst_ready))
		else $error("new byte taken while run still has results");
`endif

endmodule

`default_nettype wire
